// File: hdl/flq_pkg.sv
package flq_pkg;

  // Field widths
  localparam int ADDR_W = 20;
  localparam int PTR_W  = 21;
  localparam int LEN_W  = 11;

  // Flash geometry (powers of two)
  localparam int PAGE_BYTES   = 256;
  localparam int SECTOR_BYTES = 65536;
  localparam int MAX_RECORD   = 1024;
  localparam int PAGE_W       = $clog2(PAGE_BYTES);
  localparam int SECTOR_W     = $clog2(SECTOR_BYTES);

  // Command queue between front and back
  localparam int QUEUE_DEPTH_DEF = 2;

  // Input action codes
  localparam logic [1:0] ACT_INSERT  = 2'd0;
  localparam logic [1:0] ACT_READ    = 2'd1;
  localparam logic [1:0] ACT_ADVANCE = 2'd2;

  // Configuration register indexes
  localparam logic [1:0] CFG_REGION_START = 2'd0;
  localparam logic [1:0] CFG_SECOND_HALF  = 2'd1;
  localparam logic [1:0] CFG_REGION_LIMIT = 2'd2;

  // Configuration reset values
  localparam logic [ADDR_W-1:0] RST_REGION_START = 20'd0;
  localparam logic [ADDR_W-1:0] RST_SECOND_HALF  = 20'd589824;
  localparam logic [PTR_W-1:0]  RST_REGION_LIMIT = 21'd1048576;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_FULL    = 2'd1,
    ST_EMPTY   = 2'd2,
    ST_INVALID = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    KIND_CHUNK  = 2'd0,
    KIND_MARKER = 2'd1,
    KIND_READ   = 2'd2,
    KIND_STATUS = 2'd3
  } kind_t;

  // Classified operation handed from front to back
  typedef enum logic [2:0] {
    OP_INSERT  = 3'd0,
    OP_REJECT  = 3'd1,
    OP_READ    = 3'd2,
    OP_ADVANCE = 3'd3,
    OP_NOP     = 3'd4
  } op_t;

  typedef struct packed {
    op_t              op;
    logic [LEN_W-1:0] length;
  } cmd_t;

endpackage

// File: hdl/flq_if.sv
interface flq_item_if import flq_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [1:0]       action;
  logic [LEN_W-1:0] length;

  modport source (output valid, output action, output length, input ready);
  modport sink   (input valid, input action, input length, output ready);
endinterface

interface flq_result_if import flq_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [1:0]        status;
  logic [1:0]        kind;
  logic [ADDR_W-1:0] address;
  logic [LEN_W-1:0]  count;
  logic              erase_request;
  logic [ADDR_W-1:0] erase_address;
  logic              last;

  modport source (output valid, output status, output kind, output address, output count,
                  output erase_request, output erase_address, output last, input ready);
  modport sink   (input valid, input status, input kind, input address, input count,
                  input erase_request, input erase_address, input last, output ready);
endinterface

interface flq_cfg_if import flq_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [1:0]       index;
  logic [PTR_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// File: hdl/flash_log_queue_pointer_manager_top.sv
// Channel | Dir | Payload                                             | Transfer
// item    | in  | action, length                                      | valid & ready
// result  | out | status, kind, address, count, erase_request,        | valid & ready
//         |     | erase_address, last                                 |
// cfg     | in  | index, data                                         | valid & ready
//
// Items are decoded and queued, then executed one at a time by the back sequencer.
// Read, advance, reject, unused and full items give one result; an insert is checked first,
// then gives one result per page chunk (up to five) and one for the end marker.
// Synchronous reset restores the configuration reset values and both pointers.
// A stalled result holds the sequencer; the queue keeps taking items until full.
module flash_log_queue_pointer_manager_top import flq_pkg::*; #(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic         clk,
  input  logic         rst,
  flq_item_if.sink     item,
  flq_result_if.source result,
  flq_cfg_if.sink      cfg
);

  logic q_valid;
  logic q_ready;
  cmd_t q_cmd;

  flq_front #(
    .QUEUE_DEPTH(QUEUE_DEPTH)
  ) u_front (
    .clk     (clk),
    .rst     (rst),
    .item    (item),
    .q_valid (q_valid),
    .q_ready (q_ready),
    .q_cmd   (q_cmd)
  );

  flq_back u_back (
    .clk     (clk),
    .rst     (rst),
    .q_valid (q_valid),
    .q_ready (q_ready),
    .q_cmd   (q_cmd),
    .cfg     (cfg),
    .result  (result)
  );

endmodule

// File: hdl/flq_front.sv
module flq_front import flq_pkg::*; #(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst,
  flq_item_if.sink    item,
  output logic        q_valid,
  input  logic        q_ready,
  output cmd_t        q_cmd
);

  localparam int PTR_BITS = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_BITS = $clog2(QUEUE_DEPTH + 1);

  cmd_t                entries [QUEUE_DEPTH];
  logic [PTR_BITS-1:0] wr_ptr;
  logic [PTR_BITS-1:0] rd_ptr;
  logic [CNT_BITS-1:0] fill;
  cmd_t                cmd_in;
  logic                push;
  logic                pop;

  // Classify the incoming item
  always_comb begin
    cmd_in.length = item.length;
    unique case (item.action)
      ACT_INSERT: begin
        if (item.length == '0 || item.length > LEN_W'(MAX_RECORD)) begin
          cmd_in.op = OP_REJECT;
        end else begin
          cmd_in.op = OP_INSERT;
        end
      end
      ACT_READ:    cmd_in.op = OP_READ;
      ACT_ADVANCE: cmd_in.op = OP_ADVANCE;
      default:     cmd_in.op = OP_NOP;
    endcase
  end

  assign item.ready = (fill != CNT_BITS'(QUEUE_DEPTH));
  assign push       = item.valid && item.ready;
  assign q_valid    = (fill != '0);
  assign pop        = q_valid && q_ready;
  assign q_cmd      = entries[rd_ptr];

  // Store classified commands
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= cmd_in;
    end
  end

  // Advance queue pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        fill <= fill + 1'b1;
      end else if (pop && !push) begin
        fill <= fill - 1'b1;
      end
    end
  end

endmodule

// File: hdl/flq_back.sv
module flq_back import flq_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        q_valid,
  output logic        q_ready,
  input  cmd_t        q_cmd,
  flq_cfg_if.sink     cfg,
  flq_result_if.source result
);

  localparam int CMP_W = (LEN_W > PAGE_W + 1) ? LEN_W : PAGE_W + 1;

  typedef enum logic [1:0] {
    S_IDLE,
    S_CHUNK,
    S_MARKER
  } state_t;

  state_t            state;
  logic [ADDR_W-1:0] region_start;
  logic [ADDR_W-1:0] second_half_start;
  logic [PTR_W-1:0]  region_limit;
  logic [PTR_W-1:0]  write_pointer;
  logic [PTR_W-1:0]  read_pointer;
  logic [PTR_W-1:0]  cur_addr;
  logic [LEN_W-1:0]  left;

  logic                load;
  logic                wp_near_limit;
  logic                rp_below_half;
  logic                wp_behind_rp;
  logic                rd_wrap;
  logic [SECTOR_W-1:0] sec_off;
  logic [SECTOR_W-1:0] to_end;
  logic                adv_erase;
  logic [PAGE_W:0]     room;
  logic [LEN_W-1:0]    chunk_n;
  logic [LEN_W-1:0]    left_next;

  assign cfg.ready = 1'b1;
  assign load      = !result.valid || result.ready;
  assign q_ready   = (state == S_IDLE) && load;

  // Full and wrap checks
  assign wp_near_limit = ({1'b0, write_pointer} + (PTR_W+1)'(MAX_RECORD))
                         >= {1'b0, region_limit};
  assign rp_below_half = read_pointer < {1'b0, second_half_start};
  assign wp_behind_rp  = ({1'b0, write_pointer} + (PTR_W+1)'(SECTOR_BYTES - 1))
                         > {1'b0, read_pointer};
  assign rd_wrap       = ({1'b0, read_pointer} + (PTR_W+1)'(MAX_RECORD))
                         > {1'b0, region_limit};

  // Sector end check for advance
  assign sec_off   = read_pointer[SECTOR_W-1:0];
  assign to_end    = SECTOR_W'(SECTOR_BYTES - 1) - sec_off;
  assign adv_erase = SECTOR_W'(q_cmd.length) > to_end;

  // Page-bounded chunk size
  assign room      = (PAGE_W+1)'(PAGE_BYTES) - {1'b0, cur_addr[PAGE_W-1:0]};
  assign chunk_n   = (CMP_W'(left) < CMP_W'(room)) ? left : LEN_W'(room);
  assign left_next = left - chunk_n;

  // Sequencer, pointers, configuration and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state             <= S_IDLE;
      region_start      <= RST_REGION_START;
      second_half_start <= RST_SECOND_HALF;
      region_limit      <= RST_REGION_LIMIT;
      write_pointer     <= PTR_W'(RST_REGION_START);
      read_pointer      <= PTR_W'(RST_REGION_START);
      result.valid      <= 1'b0;
    end else begin
      // Take configuration writes; unknown indexes are dropped
      if (cfg.valid) begin
        unique case (cfg.index)
          CFG_REGION_START: region_start      <= cfg.data[ADDR_W-1:0];
          CFG_SECOND_HALF:  second_half_start <= cfg.data[ADDR_W-1:0];
          CFG_REGION_LIMIT: region_limit      <= cfg.data;
          default: ;
        endcase
      end

      if (load) begin
        result.valid         <= 1'b0;
        result.status        <= ST_OK;
        result.kind          <= KIND_STATUS;
        result.address       <= '0;
        result.count         <= '0;
        result.erase_request <= 1'b0;
        result.erase_address <= '0;
        result.last          <= 1'b1;

        unique case (state)
          S_IDLE: begin
            if (q_valid) begin
              unique case (q_cmd.op)
                OP_INSERT: begin
                  left <= q_cmd.length;
                  if (wp_near_limit) begin
                    if (rp_below_half) begin
                      result.valid  <= 1'b1;
                      result.status <= ST_FULL;
                    end else begin
                      cur_addr <= PTR_W'(region_start);
                      state    <= S_CHUNK;
                    end
                  end else if (!rp_below_half && write_pointer != read_pointer &&
                               wp_behind_rp) begin
                    result.valid  <= 1'b1;
                    result.status <= ST_FULL;
                  end else begin
                    cur_addr <= write_pointer;
                    state    <= S_CHUNK;
                  end
                end
                OP_REJECT: begin
                  result.valid  <= 1'b1;
                  result.status <= ST_INVALID;
                end
                OP_READ: begin
                  result.valid <= 1'b1;
                  if (write_pointer == read_pointer) begin
                    result.status <= ST_EMPTY;
                  end else begin
                    result.kind  <= KIND_READ;
                    result.count <= q_cmd.length;
                    if (rd_wrap) begin
                      read_pointer         <= PTR_W'(region_start);
                      result.address       <= region_start;
                      result.erase_request <= 1'b1;
                      result.erase_address <= second_half_start;
                    end else begin
                      result.address <= read_pointer[ADDR_W-1:0];
                    end
                  end
                end
                OP_ADVANCE: begin
                  result.valid  <= 1'b1;
                  read_pointer  <= read_pointer + PTR_W'(q_cmd.length) + 1'b1;
                  if (adv_erase) begin
                    result.erase_request <= 1'b1;
                    result.erase_address <= {read_pointer[ADDR_W-1:SECTOR_W],
                                             {SECTOR_W{1'b0}}};
                  end
                end
                default: begin
                  result.valid <= 1'b1;
                end
              endcase
            end
          end
          S_CHUNK: begin
            result.valid   <= 1'b1;
            result.kind    <= KIND_CHUNK;
            result.address <= cur_addr[ADDR_W-1:0];
            result.count   <= chunk_n;
            result.last    <= 1'b0;
            cur_addr       <= cur_addr + PTR_W'(chunk_n);
            left           <= left_next;
            if (left_next == '0) begin
              state <= S_MARKER;
            end
          end
          S_MARKER: begin
            result.valid   <= 1'b1;
            result.kind    <= KIND_MARKER;
            result.address <= cur_addr[ADDR_W-1:0];
            result.count   <= LEN_W'(1);
            write_pointer  <= cur_addr + 1'b1;
            state          <= S_IDLE;
          end
          default: begin
            state <= S_IDLE;
          end
        endcase
      end
    end
  end

endmodule

// File: hdl/flq_checker.sv
module flq_checker import flq_pkg::*; (
  input logic              clk,
  input logic              rst,
  input logic              res_valid,
  input logic              res_ready,
  input logic [1:0]        res_status,
  input logic [1:0]        res_kind,
  input logic [ADDR_W-1:0] res_address,
  input logic [LEN_W-1:0]  res_count,
  input logic              res_erase_request,
  input logic [ADDR_W-1:0] res_erase_address,
  input logic              res_last
);

  // Hold a result that is not taken
  a_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid && $stable(res_address) && $stable(res_kind))
    else $error("result changed while stalled");

  // Keep write chunks inside one page and never final
  a_chunk: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_kind == KIND_CHUNK |->
      !res_last && res_count != '0 &&
      ({1'b0, res_address[PAGE_W-1:0]} + (PAGE_W+1)'(res_count)) <= (PAGE_W+1)'(PAGE_BYTES))
    else $error("write chunk crosses a page or is empty");

  // End marker is one byte and closes the item
  a_marker: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_kind == KIND_MARKER |-> res_last && res_count == LEN_W'(1))
    else $error("bad end marker");

  // Error status comes alone as a status-only result
  a_error: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_status != ST_OK |->
      res_kind == KIND_STATUS && res_last && !res_erase_request)
    else $error("error status with payload");

  // No erase address without an erase request
  a_erase: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_erase_request |-> res_erase_address == '0)
    else $error("erase address without request");

endmodule

bind flash_log_queue_pointer_manager_top flq_checker u_checker (
  .clk               (clk),
  .rst               (rst),
  .res_valid         (result.valid),
  .res_ready         (result.ready),
  .res_status        (result.status),
  .res_kind          (result.kind),
  .res_address       (result.address),
  .res_count         (result.count),
  .res_erase_request (result.erase_request),
  .res_erase_address (result.erase_address),
  .res_last          (result.last)
);

// File: tb/tb.sv
module tb;
  import flq_pkg::*;

  localparam int unsigned PTR_MASK  = 32'h1F_FFFF;
  localparam int unsigned ADDR_MASK = 32'h0F_FFFF;
  localparam logic [1:0]  ACT_UNUSED = 2'd3;
  localparam logic [1:0]  CFG_UNUSED = 2'd3;

  typedef struct {
    status_t           status;
    kind_t             kind;
    logic [ADDR_W-1:0] address;
    logic [LEN_W-1:0]  count;
    logic              erase_request;
    logic [ADDR_W-1:0] erase_address;
    logic              last;
  } flash_cmd_t;

  // Tracks the log pointers and the flash commands each accepted item must produce
  class flash_log_tracker;
    int unsigned wr_ptr, rd_ptr;
    int unsigned base_addr, half_addr, limit_addr;
    flash_cmd_t  due_cmds[$];
    int          errors, n_checked, n_full, n_wraps, n_erases;
    int          n_by_action[4];

    function new();
      base_addr  = RST_REGION_START;
      half_addr  = RST_SECOND_HALF;
      limit_addr = RST_REGION_LIMIT;
      wr_ptr     = base_addr;
      rd_ptr     = base_addr;
    endfunction

    function int outstanding();
      return due_cmds.size();
    endfunction

    function void set_register(logic [1:0] index, logic [PTR_W-1:0] data);
      case (index)
        CFG_REGION_START: base_addr  = data & ADDR_MASK;
        CFG_SECOND_HALF:  half_addr  = data & ADDR_MASK;
        CFG_REGION_LIMIT: limit_addr = data & PTR_MASK;
        default: ;
      endcase
    endfunction

    function void push(status_t st, kind_t kd, int unsigned addr, int unsigned cnt,
                       bit er, int unsigned ea, bit lst);
      flash_cmd_t c;
      c.status        = st;
      c.kind          = kd;
      c.address       = addr[ADDR_W-1:0];
      c.count         = cnt[LEN_W-1:0];
      c.erase_request = er;
      c.erase_address = ea[ADDR_W-1:0];
      c.last          = lst;
      if (er) n_erases++;
      if (st == ST_FULL) n_full++;
      due_cmds.push_back(c);
    endfunction

    // Split the record at page boundaries, close it with a marker byte
    function void emit_record(int unsigned len);
      int unsigned addr, left, room, n;
      addr = wr_ptr;
      left = len;
      while (left != 0) begin
        room = PAGE_BYTES - (addr % PAGE_BYTES);
        n    = (left < room) ? left : room;
        push(ST_OK, KIND_CHUNK, addr, n, 1'b0, 0, 1'b0);
        addr = (addr + n) & PTR_MASK;
        left -= n;
      end
      push(ST_OK, KIND_MARKER, addr, 1, 1'b0, 0, 1'b1);
      wr_ptr = (wr_ptr + len + 1) & PTR_MASK;
    endfunction

    function void plan_insert(int unsigned len);
      if (len == 0 || len > MAX_RECORD) begin
        push(ST_INVALID, KIND_STATUS, 0, 0, 1'b0, 0, 1'b1);
      end else if (wr_ptr + MAX_RECORD >= limit_addr) begin
        // Near the limit: wrap only once the reader is in the second half
        if (rd_ptr < half_addr) begin
          push(ST_FULL, KIND_STATUS, 0, 0, 1'b0, 0, 1'b1);
        end else begin
          n_wraps++;
          wr_ptr = base_addr;
          emit_record(len);
        end
      end else if (rd_ptr >= half_addr && wr_ptr != rd_ptr &&
                   wr_ptr + SECTOR_BYTES - 1 > rd_ptr) begin
        push(ST_FULL, KIND_STATUS, 0, 0, 1'b0, 0, 1'b1);
      end else begin
        emit_record(len);
      end
    endfunction

    function void plan_read(int unsigned len);
      bit          er;
      int unsigned ea;
      er = 1'b0;
      ea = 0;
      if (wr_ptr == rd_ptr) begin
        push(ST_EMPTY, KIND_STATUS, 0, 0, 1'b0, 0, 1'b1);
      end else begin
        // Wrap the reader when a full record no longer fits below the limit
        if (rd_ptr + MAX_RECORD > limit_addr) begin
          rd_ptr = base_addr;
          er     = 1'b1;
          ea     = half_addr;
        end
        push(ST_OK, KIND_READ, rd_ptr, len, er, ea, 1'b1);
      end
    endfunction

    function void plan_advance(int unsigned len);
      int unsigned off, to_end, ea;
      bit          er;
      off    = rd_ptr % SECTOR_BYTES;
      to_end = SECTOR_BYTES - 1 - off;
      er     = 1'b0;
      ea     = 0;
      if (len > to_end) begin
        er = 1'b1;
        ea = rd_ptr - off;
      end
      rd_ptr = (rd_ptr + len + 1) & PTR_MASK;
      push(ST_OK, KIND_STATUS, 0, 0, er, ea, 1'b1);
    endfunction

    function void note_item(logic [1:0] action, logic [LEN_W-1:0] length);
      n_by_action[action]++;
      case (action)
        ACT_INSERT:  plan_insert(length);
        ACT_READ:    plan_read(length);
        ACT_ADVANCE: plan_advance(length);
        default:     push(ST_OK, KIND_STATUS, 0, 0, 1'b0, 0, 1'b1);
      endcase
    endfunction

    function string describe(flash_cmd_t c);
      return $sformatf("st=%0d kind=%0d addr=%h cnt=%0d er=%b ea=%h last=%b",
                       c.status, c.kind, c.address, c.count, c.erase_request,
                       c.erase_address, c.last);
    endfunction

    task report_mismatch(string msg);
      errors++;
      if (errors <= 20) $display("MISMATCH: %s", msg);
    endtask

    task check_command(flash_cmd_t got);
      flash_cmd_t want;
      string      bad;
      n_checked++;
      if (due_cmds.size() == 0) begin
        report_mismatch({"unexpected command ", describe(got)});
        return;
      end
      want = due_cmds.pop_front();
      bad  = "";
      if (got.status !== want.status)               bad = {bad, " status"};
      if (got.kind !== want.kind)                   bad = {bad, " kind"};
      if (got.address !== want.address)             bad = {bad, " address"};
      if (got.count !== want.count)                 bad = {bad, " count"};
      if (got.erase_request !== want.erase_request) bad = {bad, " erase_request"};
      if (got.erase_address !== want.erase_address) bad = {bad, " erase_address"};
      if (got.last !== want.last)                   bad = {bad, " last"};
      if (bad != "")
        report_mismatch($sformatf("command %0d bad%s: got %s / want %s", n_checked, bad,
                                  describe(got), describe(want)));
    endtask
  endclass

  logic clk;
  logic rst;
  int   snd_idle;
  int   rcv_idle;
  int   n_writes;

  flash_log_tracker board = new();

  flq_item_if   item_ch ();
  flq_result_if result_ch ();
  flq_cfg_if    cfg_ch ();

  flash_log_queue_pointer_manager_top i_dut (
    .clk    (clk),
    .rst    (rst),
    .item   (item_ch),
    .result (result_ch),
    .cfg    (cfg_ch)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Stall the result side at random
  initial begin
    result_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      result_ch.ready <= ($urandom_range(0, 99) >= rcv_idle);
    end
  end

  // Check every result transfer against the oldest pending command
  always @(posedge clk) begin : result_monitor
    flash_cmd_t got;
    if (!rst && result_ch.valid && result_ch.ready) begin
      got.status        = status_t'(result_ch.status);
      got.kind          = kind_t'(result_ch.kind);
      got.address       = result_ch.address;
      got.count         = result_ch.count;
      got.erase_request = result_ch.erase_request;
      got.erase_address = result_ch.erase_address;
      got.last          = result_ch.last;
      board.check_command(got);
    end
  end

  // Present one item, hold it until the transfer, then predict its commands
  task automatic send_item(logic [1:0] action, logic [LEN_W-1:0] length);
    while ($urandom_range(0, 99) < snd_idle) begin
      item_ch.valid <= 1'b0;
      @(posedge clk);
    end
    item_ch.valid  <= 1'b1;
    item_ch.action <= action;
    item_ch.length <= length;
    do @(posedge clk); while (!item_ch.ready);
    board.note_item(action, length);
  endtask

  // Drop valid and hold off until every predicted command has come back
  task automatic wait_drained();
    item_ch.valid <= 1'b0;
    do @(posedge clk); while (board.outstanding() != 0);
  endtask

  task automatic write_register(logic [1:0] index, logic [PTR_W-1:0] data);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= index;
    cfg_ch.data  <= data;
    do @(posedge clk); while (!cfg_ch.ready);
    board.set_register(index, data);
    n_writes++;
    cfg_ch.valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic configure(logic [PTR_W-1:0] start, logic [PTR_W-1:0] second,
                           logic [PTR_W-1:0] limit);
    wait_drained();
    repeat (8) @(posedge clk);
    write_register(CFG_REGION_START, start);
    write_register(CFG_SECOND_HALF, second);
    write_register(CFG_REGION_LIMIT, limit);
  endtask

  // Mostly insert/read/advance records of one length, some stray items between
  task automatic run_records(int n_items);
    int          sent;
    int unsigned len;
    bit          paused;
    sent   = 0;
    paused = 1'b0;
    while (sent < n_items) begin
      if (!paused && sent >= n_items / 2) begin
        wait_drained();
        paused = 1'b1;
      end
      if ($urandom_range(0, 9) < 7) begin
        case ($urandom_range(0, 9))
          0:       len = MAX_RECORD;
          1:       len = 1;
          default: len = $urandom_range(1, MAX_RECORD);
        endcase
        send_item(ACT_INSERT, LEN_W'(len));
        if ($urandom_range(0, 7) != 0) send_item(ACT_READ, LEN_W'(len));
        send_item(ACT_ADVANCE, LEN_W'(len));
        sent += 3;
      end else begin
        send_item(2'($urandom_range(0, 3)), LEN_W'($urandom_range(0, 2047)));
        sent++;
      end
    end
  endtask

  initial begin
    rst            = 1'b1;
    item_ch.valid  = 1'b0;
    item_ch.action = ACT_INSERT;
    item_ch.length = '0;
    cfg_ch.valid   = 1'b0;
    cfg_ch.index   = CFG_REGION_START;
    cfg_ch.data    = '0;
    snd_idle       = 9;
    rcv_idle       = 57;
    n_writes       = 0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // Reset settings: empty log, bad lengths, page splits, longest record
    send_item(ACT_READ, 0);
    send_item(ACT_INSERT, 0);
    send_item(ACT_INSERT, 1025);
    send_item(ACT_INSERT, 2047);
    send_item(ACT_UNUSED, 2047);
    send_item(ACT_INSERT, 1);
    send_item(ACT_INSERT, 1024);
    send_item(ACT_INSERT, 255);
    send_item(ACT_INSERT, 256);
    send_item(ACT_READ, 1);
    send_item(ACT_ADVANCE, 1);
    send_item(ACT_READ, 1024);
    send_item(ACT_ADVANCE, 1024);
    send_item(ACT_READ, 2047);
    send_item(ACT_ADVANCE, 2047);
    send_item(ACT_ADVANCE, 0);
    send_item(ACT_UNUSED, 0);

    // Small region whose wrap target sits just below a sector end
    configure(21'h0_FF80, 21'h0_0800, 21'h0_2000);
    run_records(28);

    snd_idle = 57;
    rcv_idle = 9;
    configure(21'h1F_FFFF, 21'h0_0000, 21'h1F_FFFF);
    run_records(28);

    configure(21'h00_0000, 21'h0F_FFFF, 21'h00_0000);
    write_register(CFG_UNUSED, 21'h1F_FFFF);
    run_records(28);

    snd_idle = 0;
    rcv_idle = 0;
    configure(PTR_W'($urandom_range(0, 21'h0F_FFFF)), PTR_W'($urandom_range(0, 21'h0F_FFFF)),
              PTR_W'($urandom_range(0, 21'h01_FFFF)));
    run_records(28);

    wait_drained();
    repeat (20) @(posedge clk);
    if (board.outstanding() != 0)
      board.report_mismatch($sformatf("%0d commands never arrived", board.outstanding()));

    $display("Run covered %0d items (%0d insert, %0d read, %0d advance, %0d unused)",
             board.n_by_action[0] + board.n_by_action[1] + board.n_by_action[2] +
             board.n_by_action[3], board.n_by_action[ACT_INSERT],
             board.n_by_action[ACT_READ], board.n_by_action[ACT_ADVANCE],
             board.n_by_action[ACT_UNUSED]);
    $display("Checked %0d commands: %0d log full, %0d write wraps, %0d erase requests, %0d writes",
             board.n_checked, board.n_full, board.n_wraps, board.n_erases, n_writes);
    if (board.errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  // Bound the run well above the slowest legal completion
  initial begin
    #2_000_000;
    $display("Timeout with %0d commands outstanding", board.outstanding());
    $display("*** FAILED ***");
    $finish;
  end

endmodule
